// File: rtl/text_console_writer_defines.svh
// Assertion macros shared by the text console writer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication
`define TCW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Used by the controller, the datapath, the RAM and the top level.
`default_nettype none

package tcw_pkg;

   localparam int TCW_COLS = 80;
   localparam int TCW_ROWS = 25;
   localparam int CELL_W   = 16;

   localparam int KIND_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int TROW_W      = 5;
   localparam int TCOL_W      = 7;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [CHAR_W-1:0] CH_MARK     = 8'h5F;
   localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0A;
   localparam logic [CHAR_W-1:0] COLOR_RESET = 8'd15;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUT   = 2'd0,
      KIND_READ  = 2'd1,
      KIND_SET   = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      WD_CHAR  = 3'd0,
      WD_MARK  = 3'd1,
      WD_SPACE = 3'd2,
      WD_COPY  = 3'd3,
      WD_ZERO  = 3'd4
   } wd_sel_type;

   typedef enum logic [2:0] {
      AD_CUR      = 3'd0,
      AD_CUR_NEXT = 3'd1,
      AD_PTR      = 3'd2,
      AD_PTR_SRC  = 3'd3,
      AD_TARGET   = 3'd4
   } addr_sel_type;

   typedef enum logic [1:0] {
      CUR_HOLD    = 2'd0,
      CUR_INC_COL = 2'd1,
      CUR_NEWLINE = 2'd2,
      CUR_SET     = 2'd3
   } cur_op_type;

   typedef enum logic [1:0] {
      PTR_HOLD = 2'd0,
      PTR_ZERO = 2'd1,
      PTR_INC  = 2'd2
   } ptr_op_type;

   typedef struct packed {
      logic         item_ld;
      logic         wr_en;
      wd_sel_type   wd_sel;
      addr_sel_type addr_sel;
      logic         rd_en;
      cur_op_type   cur_op;
      ptr_op_type   ptr_op;
      logic         rsp_ld;
   } cmd_type;

   typedef struct packed {
      kind_type req_kind;
      logic     req_newline;
      logic     col_full;
      logic     mark_ok;
      logic     row_last;
      logic     copy_end;
      logic     fill_end;
      logic     rsp_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the screen cells; depends on tcw_pkg for default sizes.
`default_nettype none

module tcw_ram #(
   parameter int  WIDTH = tcw_pkg::CELL_W,
   parameter int  DEPTH = tcw_pkg::TCW_ROWS * tcw_pkg::TCW_COLS,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/tcw_dp.sv
// Datapath: item latch, cursor, sweep pointer, color register, cell RAM, result register.
// Driven by tcw_ctrl through cmd_type; depends on tcw_pkg and tcw_ram.
`default_nettype none

`include "text_console_writer_defines.svh"

module tcw_dp #(
   parameter int COLS = tcw_pkg::TCW_COLS,
   parameter int ROWS = tcw_pkg::TCW_ROWS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire tcw_pkg::cmd_type                   cmd,
   output tcw_pkg::status_type                     st,
   input  wire logic [tcw_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic [tcw_pkg::KIND_W-1:0]         req_tuser,
   input  wire logic                               csr_we,
   input  wire logic [tcw_pkg::CHAR_W-1:0]         csr_wdata,
   input  wire logic                               rsp_tready,
   output logic                                    rsp_tvalid,
   output logic      [tcw_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLS + 1);

   // item fields
   kind_type            kind_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic [TROW_W-1:0]   trow_ff;
   logic [TCOL_W-1:0]   tcol_ff;

   logic [CHAR_W-1:0]   color_ff;
   logic [RW-1:0]       cur_row_ff, cur_row_in;
   logic [CW-1:0]       cur_col_ff, cur_col_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_color_ff;
   logic [TROW_W-1:0]   rsp_row_ff;
   logic [TCOL_W-1:0]   rsp_col_ff;

   logic [RW-1:0]       set_row;
   logic [CW-1:0]       set_col, rd_col, col_next, sel_col;
   logic [RW-1:0]       sel_row;
   logic [AW-1:0]       cell_addr, addr;
   logic [CELL_W-1:0]   wdata, rdata;

   // clamped targets
   assign set_row  = (32'(trow_ff) > ROWS - 1) ? RW'(ROWS - 1) : RW'(trow_ff);
   assign set_col  = (32'(tcol_ff) > COLS) ? CW'(COLS) : CW'(tcol_ff);
   assign rd_col   = (32'(tcol_ff) > COLS - 1) ? CW'(COLS - 1) : CW'(tcol_ff);
   assign col_next = CW'(cur_col_ff + CW'(1));

   always_comb begin
      sel_row = cur_row_ff;
      sel_col = cur_col_ff;
      unique case (cmd.addr_sel)
         AD_CUR_NEXT: sel_col = col_next;
         AD_TARGET: begin
            sel_row = set_row;
            sel_col = rd_col;
         end
         default: ;
      endcase
   end

   assign cell_addr = AW'(32'(sel_row) * COLS + 32'(sel_col));

   always_comb begin
      unique case (cmd.addr_sel)
         AD_PTR:     addr = ptr_ff;
         AD_PTR_SRC: addr = AW'(32'(ptr_ff) + COLS);
         default:    addr = cell_addr;
      endcase
   end

   always_comb begin
      unique case (cmd.wd_sel)
         WD_CHAR:  wdata = {color_ff, char_ff};
         WD_MARK:  wdata = {color_ff, CH_MARK};
         WD_SPACE: wdata = {color_ff, CH_SPACE};
         WD_COPY:  wdata = rdata;
         default:  wdata = '0;
      endcase
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_ram (
      .clock (clock),
      .we    (cmd.wr_en),
      .waddr (addr),
      .wdata (wdata),
      .re    (cmd.rd_en),
      .raddr (addr),
      .rdata (rdata)
   );

   // cursor and pointer updates
   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      unique case (cmd.cur_op)
         CUR_INC_COL: cur_col_in = col_next;
         CUR_NEWLINE: begin
            cur_col_in = '0;
            if (!st.row_last) begin
               cur_row_in = RW'(cur_row_ff + RW'(1));
            end
         end
         CUR_SET: begin
            cur_row_in = set_row;
            cur_col_in = set_col;
         end
         default: ;
      endcase
   end

   always_comb begin
      unique case (cmd.ptr_op)
         PTR_ZERO: ptr_in = '0;
         PTR_INC:  ptr_in = AW'(ptr_ff + AW'(1));
         default:  ptr_in = ptr_ff;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_ld | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= COLOR_RESET;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            color_ff <= csr_wdata;
         end
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_ld) begin
         kind_ff <= kind_type'(req_tuser);
         char_ff <= req_tdata[7:0];
         trow_ff <= req_tdata[12:8];
         tcol_ff <= req_tdata[19:13];
      end
      if (cmd.rsp_ld) begin
         // cursor fields take this cycle's update
         rsp_row_ff <= TROW_W'(cur_row_in);
         rsp_col_ff <= TCOL_W'(cur_col_in);
         if (kind_ff == KIND_READ) begin
            rsp_char_ff  <= rdata[7:0];
            rsp_color_ff <= rdata[15:8];
         end else begin
            rsp_char_ff  <= '0;
            rsp_color_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_col_ff, rsp_row_ff, rsp_color_ff, rsp_char_ff};

   // status to the controller
   assign st.req_kind    = kind_type'(req_tuser);
   assign st.req_newline = (req_tdata[7:0] == CH_NEWLINE);
   assign st.col_full    = (32'(cur_col_ff) >= COLS);
   assign st.mark_ok     = (32'(cur_col_ff) + 1 < COLS);
   assign st.row_last    = (32'(cur_row_ff) >= ROWS - 1);
   assign st.copy_end    = (32'(ptr_ff) == CELLS - COLS - 1);
   assign st.fill_end    = (32'(ptr_ff) == CELLS - 1);
   assign st.rsp_free    = ~rsp_valid_ff | rsp_tready;

   `TCW_ASSERT_IMP(a_col_range, clock, reset, 1'b1, 32'(cur_col_ff) <= COLS, "cursor column past row end")
   `TCW_ASSERT_IMP(a_row_range, clock, reset, 1'b1, 32'(cur_row_ff) <= ROWS - 1, "cursor row past last row")
   `TCW_ASSERT_IMP(a_cur_write, clock, reset, cmd.wr_en && (cmd.addr_sel == AD_CUR), !st.col_full, "cell write at full-row cursor")

endmodule

`default_nettype wire

// File: rtl/tcw_ctrl.sv
// Controller state machine: sequences the reset-time zeroing, puts, newlines, scrolls, clears, reads and cursor sets.
// Talks to tcw_dp through cmd_type and status_type; depends on tcw_pkg.
`default_nettype none

`include "text_console_writer_defines.svh"

module tcw_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire tcw_pkg::status_type st,
   output tcw_pkg::cmd_type         cmd
);

   import tcw_pkg::*;

   typedef enum logic [12:0] {
      S_INIT     = 13'b0000000000001,
      S_IDLE     = 13'b0000000000010,
      S_PUT_CH   = 13'b0000000000100,
      S_PUT_MK   = 13'b0000000001000,
      S_NL_BLANK = 13'b0000000010000,
      S_NL_MARK  = 13'b0000000100000,
      S_SCR_RD   = 13'b0000001000000,
      S_SCR_WR   = 13'b0000010000000,
      S_FILL     = 13'b0000100000000,
      S_RD       = 13'b0001000000000,
      S_RD_WAIT  = 13'b0010000000000,
      S_SET      = 13'b0100000000000,
      S_RESP     = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;   // a put waits behind the current newline
   logic      finish;

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      finish       = 1'b0;
      req_tready   = 1'b0;
      cmd.item_ld  = 1'b0;
      cmd.wr_en    = 1'b0;
      cmd.wd_sel   = WD_SPACE;
      cmd.addr_sel = AD_CUR;
      cmd.rd_en    = 1'b0;
      cmd.cur_op   = CUR_HOLD;
      cmd.ptr_op   = PTR_HOLD;
      cmd.rsp_ld   = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            cmd.wr_en    = 1'b1;
            cmd.wd_sel   = WD_ZERO;
            cmd.addr_sel = AD_PTR;
            cmd.ptr_op   = PTR_INC;
            if (st.fill_end) begin
               cmd.ptr_op = PTR_ZERO;
               state_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.item_ld = 1'b1;
               pend_in     = 1'b0;
               unique case (st.req_kind)
                  KIND_PUT: begin
                     if (st.req_newline) begin
                        state_in = S_NL_BLANK;
                     end else if (st.col_full) begin
                        pend_in  = 1'b1;
                        state_in = S_NL_BLANK;
                     end else begin
                        state_in = S_PUT_CH;
                     end
                  end
                  KIND_READ: state_in = S_RD;
                  KIND_SET:  state_in = S_SET;
                  KIND_CLEAR: begin
                     cmd.ptr_op = PTR_ZERO;
                     state_in   = S_FILL;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_PUT_CH: begin
            cmd.wr_en  = 1'b1;
            cmd.wd_sel = WD_CHAR;
            state_in   = S_PUT_MK;
         end
         S_PUT_MK: begin
            // marker only while it stays inside the row
            cmd.wr_en    = st.mark_ok;
            cmd.wd_sel   = WD_MARK;
            cmd.addr_sel = AD_CUR_NEXT;
            cmd.cur_op   = CUR_INC_COL;
            finish       = 1'b1;
         end
         S_NL_BLANK: begin
            cmd.wr_en  = ~st.col_full;
            cmd.cur_op = CUR_NEWLINE;
            if (st.row_last) begin
               cmd.ptr_op = PTR_ZERO;
               state_in   = S_SCR_RD;
            end else begin
               state_in = S_NL_MARK;
            end
         end
         S_NL_MARK: begin
            cmd.wr_en  = 1'b1;
            cmd.wd_sel = WD_MARK;
            if (pend_ff) begin
               pend_in  = 1'b0;
               state_in = S_PUT_CH;
            end else begin
               finish = 1'b1;
            end
         end
         S_SCR_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = AD_PTR_SRC;
            state_in     = S_SCR_WR;
         end
         S_SCR_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wd_sel   = WD_COPY;
            cmd.addr_sel = AD_PTR;
            cmd.ptr_op   = PTR_INC;
            // pointer lands on the bottom row for the blanking sweep
            state_in     = st.copy_end ? S_FILL : S_SCR_RD;
         end
         S_FILL: begin
            cmd.wr_en    = 1'b1;
            cmd.addr_sel = AD_PTR;
            cmd.ptr_op   = PTR_INC;
            if (st.fill_end) begin
               if (pend_ff) begin
                  pend_in  = 1'b0;
                  state_in = S_PUT_CH;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         S_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = AD_TARGET;
            state_in     = S_RD_WAIT;
         end
         S_RD_WAIT: finish = 1'b1;
         S_SET: begin
            cmd.cur_op = CUR_SET;
            finish     = 1'b1;
         end
         S_RESP: finish = 1'b1;
         default: state_in = S_IDLE;
      endcase

      if (finish) begin
         cmd.rsp_ld = st.rsp_free;
         state_in   = st.rsp_free ? S_IDLE : S_RESP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   `TCW_ASSERT_IMP(a_rsp_slot, clock, reset, cmd.rsp_ld, st.rsp_free, "result loaded over a pending result")
   `TCW_ASSERT_NXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "second transaction taken while busy")
   `TCW_ASSERT_IMP(a_quiet_wr, clock, reset, (state_ff == S_IDLE) || (state_ff == S_RESP), !cmd.wr_en, "cell write outside a work step")

endmodule

`default_nettype wire

// File: rtl/text_console_writer.sv
// Text console writer: ROWS x COLS screen of character/color cells with a cursor.
// Request transactions (req_*): tuser carries the kind (put, read, set cursor, clear),
//   tdata carries char_code, target_row and target_col.
// Result transactions (rsp_*): one per request, with the read cell (zero unless a read)
//   and the cursor position after the request.
// csr_we/csr_wdata set the color of written chars, markers and blanks; write it while idle.
// Request steps: a newline on the last row scrolls the screen up one row and blanks the
//   bottom row; a clear blanks every cell. A put at a full row adds the newline first.
//   The cell RAM has a single write port and a registered read port; one request is in
//   flight at a time.
// The next request is accepted in the cycle after the result is loaded.
// The result sits in an output register, so the next request is accepted while the
// previous result waits; a stalled receiver only holds back the end of the next request.
// After reset the block zeroes all ROWS*COLS cells, one per cycle, with req_tready low;
// color resets to 15 and the cursor to row 0, column 0.
`default_nettype none

module text_console_writer #(
   parameter int COLS = tcw_pkg::TCW_COLS,
   parameter int ROWS = tcw_pkg::TCW_ROWS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [7:0] char_code, [12:8] target_row, [19:13] target_col, [23:20] zero
   input  wire logic [tcw_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] kind
   input  wire logic [tcw_pkg::KIND_W-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [7:0] cell_char, [15:8] cell_color, [20:16] cursor_row, [27:21] cursor_col, [31:28] zero
   output logic      [tcw_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [tcw_pkg::CHAR_W-1:0]       csr_wdata
);

   import tcw_pkg::*;

   cmd_type    cmd;
   status_type st;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   tcw_dp #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: dv/text_console_writer_tb.sv
// Self-checking testbench for text_console_writer: streams put, read, set and clear
// transactions, predicts every screen cell and the cursor, and checks each result.
// Depends on tcw_pkg and the text_console_writer RTL only.
`timescale 1ns / 100ps

module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int COLS             = TCW_COLS;
   localparam int ROWS             = TCW_ROWS;
   localparam int PHASE_ITEMS      = 150;
   localparam int DRAIN_CYCLES     = 16;
   localparam int LONG_HOLD_AT     = 60;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int STALL_LIMIT      = 20000;
   localparam int CYCLE_LIMIT      = 12000000;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
      logic [4:0] row;
      logic [6:0] col;
   } console_req_type;

   typedef struct packed {
      logic [7:0] ch;
      logic [7:0] color;
      logic [4:0] row;
      logic [6:0] col;
   } console_rsp_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CHAR_W-1:0]      csr_wdata  = '0;

   // shadow of the console
   logic [15:0]  screen [ROWS*COLS];
   int           cur_row;
   int           cur_col;
   logic [7:0]   text_color;

   console_req_type req_backlog [$];
   console_rsp_type awaited_rsps [$];
   console_req_type req_item;
   int           send_gap;
   int           recv_wait;
   int           hold_left;
   int           rsp_count;
   int           errors;
   int           cycle_count;
   int           quiet_cycles;
   bit           calm_phase;

   text_console_writer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void put_cell(int r, int c, logic [7:0] ch);
      if (r < ROWS && c < COLS) begin
         screen[r*COLS + c] = {text_color, ch};
      end
   endfunction

   function automatic void line_feed();
      int i;
      if (cur_col < COLS) begin
         put_cell(cur_row, cur_col, CH_SPACE);
      end
      cur_col = 0;
      if (cur_row < ROWS - 1) begin
         cur_row++;
         put_cell(cur_row, 0, CH_MARK);
      end else begin
         // scroll up one row, bottom row becomes blanks
         for (i = 0; i < (ROWS - 1) * COLS; i++) begin
            screen[i] = screen[i + COLS];
         end
         for (i = 0; i < COLS; i++) begin
            put_cell(ROWS - 1, i, CH_SPACE);
         end
      end
   endfunction

   function automatic console_rsp_type console_apply(console_req_type q);
      console_rsp_type r;
      int rr;
      int cc;
      r = '0;
      case (q.kind)
         KIND_PUT: begin
            if (q.ch == CH_NEWLINE) begin
               line_feed();
            end else begin
               if (cur_col >= COLS) begin
                  line_feed();
               end
               put_cell(cur_row, cur_col, q.ch);
               if (cur_col + 1 < COLS) begin
                  put_cell(cur_row, cur_col + 1, CH_MARK);
               end
               cur_col++;
            end
         end
         KIND_READ: begin
            rr = (q.row > ROWS - 1) ? ROWS - 1 : int'(q.row);
            cc = (q.col > COLS - 1) ? COLS - 1 : int'(q.col);
            {r.color, r.ch} = screen[rr*COLS + cc];
         end
         KIND_SET: begin
            cur_row = (q.row > ROWS - 1) ? ROWS - 1 : int'(q.row);
            cur_col = (q.col > COLS) ? COLS : int'(q.col);
         end
         default: begin
            for (rr = 0; rr < ROWS * COLS; rr++) begin
               screen[rr] = {text_color, CH_SPACE};
            end
         end
      endcase
      r.row = 5'(cur_row);
      r.col = 7'(cur_col);
      return r;
   endfunction

   function automatic void add_req(kind_type k, logic [7:0] ch, logic [4:0] row,
                                   logic [6:0] col);
      console_req_type q;
      q.kind = k;
      q.ch   = ch;
      q.row  = row;
      q.col  = col;
      req_backlog.push_back(q);
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: result %0d %s mismatch: expected 0x%0h, got 0x%0h",
                  $time, rsp_count, name, want, got);
         errors++;
      end
   endfunction

   task automatic wait_idle();
      while (req_backlog.size() != 0 || awaited_rsps.size() != 0 || req_tvalid) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
         for (int i = 0; i < ROWS * COLS; i++) begin
            screen[i] = '0;
         end
         cur_row    = 0;
         cur_col    = 0;
         text_color = COLOR_RESET;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_rsps.push_back(console_apply(req_item));
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0 || req_backlog.size() == 0) begin
               if (send_gap > 0) begin
                  send_gap--;
               end
               req_tvalid <= 1'b0;
            end else begin
               req_item = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= req_item.kind;
               req_tdata  <= {4'd0, req_item.col, req_item.row, req_item.ch};
               send_gap = calm_phase ? 0 : $urandom_range(0, 7);
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      console_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (awaited_rsps.size() == 0) begin
               $display("%0t: result %0d with no transaction outstanding, got 0x%0h",
                        $time, rsp_count, rsp_tdata);
               errors++;
            end else begin
               want = awaited_rsps.pop_front();
               check_field("cell_char", want.ch, rsp_tdata[7:0]);
               check_field("cell_color", want.color, rsp_tdata[15:8]);
               check_field("cursor_row", want.row, rsp_tdata[20:16]);
               check_field("cursor_col", want.col, rsp_tdata[27:21]);
            end
            recv_wait = calm_phase ? 0 : $urandom_range(0, 7);
            // long backpressure so the block fills and stalls its input
            if (rsp_count == LONG_HOLD_AT) begin
               hold_left = LONG_HOLD_CYCLES;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles > STALL_LIMIT || cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, awaited_rsps.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int         p;
      int         r;
      int         c;
      int         n;
      int         k;
      int         i;
      logic [7:0] color;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset contents, char extremes, full rows, scrolls, saturation
      add_req(KIND_READ, 8'h00, 5'd0, 7'd0);
      add_req(KIND_PUT, 8'h41, 5'd0, 7'd0);
      add_req(KIND_PUT, 8'h00, 5'd0, 7'd0);
      add_req(KIND_PUT, 8'hFF, 5'd0, 7'd0);
      add_req(KIND_READ, 8'h00, 5'd0, 7'd3);
      add_req(KIND_PUT, CH_NEWLINE, 5'd0, 7'd0);
      add_req(KIND_READ, 8'h00, 5'd0, 7'd3);
      add_req(KIND_READ, 8'h00, 5'd1, 7'd0);
      add_req(KIND_SET, 8'h00, 5'd31, 7'd127);
      add_req(KIND_READ, 8'h00, 5'd31, 7'd127);
      add_req(KIND_PUT, 8'h42, 5'd0, 7'd0);      // wrap on last row scrolls first
      add_req(KIND_READ, 8'h00, 5'd23, 7'd0);
      add_req(KIND_SET, 8'h00, 5'd24, 7'd79);
      add_req(KIND_PUT, 8'h43, 5'd0, 7'd0);      // no marker past the row end
      add_req(KIND_READ, 8'h00, 5'd24, 7'd79);
      add_req(KIND_PUT, CH_NEWLINE, 5'd0, 7'd0); // full row newline, scroll
      add_req(KIND_READ, 8'h00, 5'd23, 7'd79);
      add_req(KIND_SET, 8'h00, 5'd3, 7'd80);
      add_req(KIND_PUT, CH_NEWLINE, 5'd0, 7'd0);
      add_req(KIND_SET, 8'h00, 5'd5, 7'd79);
      add_req(KIND_PUT, 8'h44, 5'd0, 7'd0);
      add_req(KIND_PUT, 8'h45, 5'd0, 7'd0);
      add_req(KIND_READ, 8'h00, 5'd6, 7'd1);
      add_req(KIND_CLEAR, 8'h00, 5'd0, 7'd0);
      add_req(KIND_READ, 8'h00, 5'd12, 7'd40);

      for (p = 0; p < 6; p++) begin
         wait_idle();
         color = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom_range(0, 255));
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_wdata <= color;
         @(posedge clock);
         csr_we    <= 1'b0;
         text_color = color;
         @(negedge clock);
         calm_phase = (p == 3);
         while (req_backlog.size() < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 15) begin
               // noise: any kind, any field values
               add_req(kind_type'(KIND_W'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                       5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
            end else begin
               // place the cursor, type a few bytes, read back around them
               r = ($urandom_range(0, 6) == 0) ? $urandom_range(25, 31) : $urandom_range(0, 24);
               c = ($urandom_range(0, 3) == 0) ? $urandom_range(74, 80) : $urandom_range(0, 80);
               if ($urandom_range(0, 15) == 0) begin
                  c = $urandom_range(81, 127);
               end
               n = $urandom_range(1, 8);
               k = $urandom_range(1, 4);
               add_req(KIND_SET, 8'($urandom_range(0, 255)), 5'(r), 7'(c));
               for (i = 0; i < n; i++) begin
                  add_req(KIND_PUT,
                          ($urandom_range(0, 7) == 0) ? CH_NEWLINE : 8'($urandom_range(0, 255)),
                          5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
               end
               for (i = 0; i < k; i++) begin
                  add_req(KIND_READ, 8'($urandom_range(0, 255)),
                          5'(r + int'($urandom_range(0, 2)) - 1),
                          7'((c > 80 ? 80 : c) + int'($urandom_range(0, n + 1))));
               end
            end
         end
      end

      wait_idle();
      if (errors == 0 && awaited_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_dp.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer.sv
dv/text_console_writer_tb.sv
